// ===== rtl/sparse_linear_value_table_macros.svh =====
// Assertion macros for the sparse linear value table.
// SLVT_ASSERT_NOW: condition implies consequence in the same cycle.
// SLVT_ASSERT_NXT: condition implies consequence in the following cycle.
`ifndef SPARSE_LINEAR_VALUE_TABLE_MACROS_SVH
`define SPARSE_LINEAR_VALUE_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define SLVT_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("slvt assertion failed");
`define SLVT_ASSERT_NXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("slvt assertion failed");
`else
`define SLVT_ASSERT_NOW(label, cond, cons)
`define SLVT_ASSERT_NXT(label, cond, cons)
`endif
`endif

// ===== rtl/slvt_pkg.sv =====
// ---------------------------------------------------------------------------
// slvt_pkg
// Types, codes and saturation helpers of the sparse linear value table.
// ---------------------------------------------------------------------------
`default_nettype none
package slvt_pkg;

    // request codes
    localparam logic [1:0] REQ_GET = 2'd0;
    localparam logic [1:0] REQ_UPD = 2'd1;
    localparam logic [1:0] REQ_SET = 2'd2;

    // configuration register indexes
    localparam logic CFG_ALLOW = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [46:0] LIMIT_RESET = 47'd6553600000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [9:0]         feature_index;
        logic [16:0]        activation;
        logic signed [31:0] operand_value;
        logic               last_feature;
    } t_in_word;

    typedef struct packed {
        logic signed [47:0] value_sum;
        logic               diverged;
    } t_out_word;

    // classified item passed from front to back
    typedef struct packed {
        t_in_word word;
        logic     in_range;
    } t_item;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_MUL,
        B_APPLY
    } t_bstate;

    // clamp a 35-bit value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
            r = v[31:0];
        end else if (v[34]) begin
            r = {1'b1, 31'd0};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    // clamp a 49-bit value to signed 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v[48] == v[47]) begin
            r = v[47:0];
        end else if (v[48]) begin
            r = {1'b1, 47'd0};
        end else begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sparse_linear_value_table.sv =====
// Sparse linear value table. Each input word carries one active feature of
// a request (get, update or set); the word marked last yields one result
// with the Q32.16 sum and a divergence flag. The back end takes one item at
// a time through memory read, registered read data, multiply and apply,
// since each item is a read-modify-write of the weight memory, which has one
// write port and one read port; a two-word queue lets the front keep accepting
// meanwhile. After reset a clearing pass zeroes the table, with the input stalled.
// ---------------------------------------------------------------------------
// sparse_linear_value_table
// Top level: configuration registers, front end queue and back end.
// ---------------------------------------------------------------------------
`default_nettype none
module sparse_linear_value_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire  [46:0]          i_cfg_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  slvt_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output slvt_pkg::t_out_word  o_out_data
);
    import slvt_pkg::*;

    logic        r_allow_div;
    logic [46:0] r_limit;
    logic        q_valid, q_pop, clr_busy;
    t_item       q_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_div <= 1'b0;
            r_limit     <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALLOW: r_allow_div <= i_cfg_data[0];
                CFG_LIMIT: r_limit     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    slvt_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_clr_busy (clr_busy),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    slvt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_allow_div (r_allow_div),
        .i_limit     (r_limit),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_clr_busy  (clr_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/slvt_front.sv =====
// ---------------------------------------------------------------------------
// slvt_front
// Accepts input words, checks the index against the table depth and holds
// them in a two-entry queue for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module slvt_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  slvt_pkg::t_in_word   i_in_data,
    input  wire                  i_clr_busy,
    output logic                 o_q_valid,
    output slvt_pkg::t_item      o_q_item,
    input  wire                  i_q_pop
);
    import slvt_pkg::*;

    localparam logic [16:0] DEPTH_W = 17'(TABLE_DEPTH);

    t_item      r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    t_item      item;

    assign o_in_stall = (r_count == 2'd2) || i_clr_busy;
    assign push       = i_in_valid && !o_in_stall;

    // classify: index within the table
    always_comb begin
        item.word     = i_in_data;
        item.in_range = {7'd0, i_in_data.feature_index} < DEPTH_W;
    end

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/slvt_back.sv =====
// ---------------------------------------------------------------------------
// slvt_back
// Weight memory, clearing pass, multiplier and accumulator. Runs one queued
// item through read, multiply and apply, and drives the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sparse_linear_value_table_macros.svh"
module slvt_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_allow_div,
    input  wire  [46:0]          i_limit,
    input  wire                  i_q_valid,
    input  slvt_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    output logic                 o_clr_busy,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output slvt_pkg::t_out_word  o_out_data
);
    import slvt_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    logic signed [31:0] r_mem [TABLE_DEPTH];
    logic signed [31:0] r_rd_data;

    t_bstate            r_state, n_state;
    t_item              r_item;
    logic signed [49:0] r_prod;
    logic signed [47:0] r_sum, n_sum;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic [AW-1:0]      item_addr;
    logic               load;
    logic signed [31:0] mul_x;
    logic signed [49:0] rnd;
    logic signed [33:0] sc;
    logic signed [47:0] acc;
    logic signed [47:0] res_sum;
    logic signed [48:0] s_ext, lim_ext;
    logic               out_free;

    assign item_addr   = AW'(r_item.word.feature_index);
    assign o_clr_busy  = r_clr_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    // weight memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[item_addr];
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // datapath arithmetic; an index beyond the table reads as weight zero
    always_comb begin
        if (r_item.word.req_type == REQ_GET) begin
            mul_x = r_item.in_range ? r_rd_data : 32'sd0;
        end else begin
            mul_x = r_item.word.operand_value;
        end
        rnd     = r_prod + 50'sd32768;
        sc      = rnd[49:16];
        acc     = sat48({r_sum[47], r_sum} + {{15{sc[33]}}, sc});
        res_sum = (r_item.word.req_type == REQ_GET) ? acc : 48'sd0;
        s_ext   = {res_sum[47], res_sum};
        lim_ext = {2'b00, i_limit};
    end

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_q_item;
        end
        if (r_state == B_MUL) begin
            r_prod <= {{18{mul_x[31]}}, mul_x} * $signed({33'd0, r_item.word.activation});
        end
        r_out <= n_out;
    end

    // next state and controls
    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        load        = 1'b0;
        o_q_pop     = 1'b0;
        wr_en       = r_clr_busy;
        wr_addr     = r_clr_addr;
        wr_data     = 32'sd0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid && !r_clr_busy) begin
                    load    = 1'b1;
                    o_q_pop = 1'b1;
                    n_state = B_READ;
                end
            end
            B_READ: begin
                n_state = B_MUL;
            end
            B_MUL: begin
                n_state = B_APPLY;
            end
            B_APPLY: begin
                if (!r_item.word.last_feature || out_free) begin
                    n_state = B_IDLE;
                    wr_addr = item_addr;
                    unique case (r_item.word.req_type)
                        REQ_GET: begin
                            n_sum = acc;
                        end
                        REQ_UPD: begin
                            wr_en   = r_item.in_range;
                            wr_data = sat32({{3{r_rd_data[31]}}, r_rd_data}
                                            + {sc[33], sc});
                        end
                        REQ_SET: begin
                            wr_en   = r_item.in_range;
                            wr_data = sat32({sc[33], sc});
                        end
                        default: begin
                        end
                    endcase
                    if (r_item.word.last_feature) begin
                        n_sum             = '0;
                        n_out_valid       = 1'b1;
                        n_out.value_sum   = res_sum;
                        n_out.diverged    = !i_allow_div
                                            && (s_ext > lim_ext || s_ext < -lim_ext);
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    `SLVT_ASSERT_NOW(a_clr_idle, r_clr_busy, r_state == B_IDLE)
    `SLVT_ASSERT_NXT(a_read_to_mul, r_state == B_READ, r_state == B_MUL)
    `SLVT_ASSERT_NOW(a_div_nonzero, r_out_valid && r_out.diverged, r_out.value_sum != 48'sd0)

endmodule
`default_nettype wire
